// ----- rtl/sitoa_pkg.sv -----
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, types and elaboration helpers for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int STEP_BITS       = 4;     // binary bits folded into BCD per cycle
    localparam int QUEUE_DEPTH     = 2;
    localparam longint unsigned RADIX = 64'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Valid and sign flags carried between the stages, from the front to the emitter.
    typedef struct packed {
        logic valid;
        logic negative;
    } sitoa_ctl_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } sitoa_conv_state_t;

    // Decimal digits of the largest magnitude, 2^(w-1).
    function automatic int num_digits(input int w);
        longint unsigned v;
        int n;
        v = 64'd1 << (w - 1);
        n = 0;
        while (v != 64'd0) begin
            v = v / RADIX;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ----- rtl/sitoa_front.sv -----
// ----------------------------------------------------------------------------
// sitoa_front
// Input register; splits each value into a sign flag and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitoa_front #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [VALUE_WIDTH-1:0]   value,
    output sitoa_pkg::sitoa_ctl_t    push,
    output logic [VALUE_WIDTH-1:0]   push_mag,
    input  logic                     push_ready
);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   take;

    assign item_stall = valid_reg && !push_ready;
    assign take       = !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            value_reg <= value;
        end
    end

    // Magnitude stays unsigned, so the most negative value maps to 2^(W-1).
    assign push.valid    = valid_reg;
    assign push.negative = value_reg[VALUE_WIDTH-1];
    assign push_mag      = value_reg[VALUE_WIDTH-1] ? (~value_reg + VALUE_WIDTH'(1))
                                                    : value_reg;

endmodule

// ----- rtl/sitoa_queue.sv -----
// ----------------------------------------------------------------------------
// sitoa_queue
// Short FIFO of classified items between the front and the converter.
// ----------------------------------------------------------------------------
module sitoa_queue #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sitoa_pkg::sitoa_ctl_t    push,
    input  logic [VALUE_WIDTH-1:0]   push_mag,
    output logic                     push_ready,
    output sitoa_pkg::sitoa_ctl_t    head,
    output logic [VALUE_WIDTH-1:0]   head_mag,
    input  logic                     pop
);

    localparam int DEPTH = sitoa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   neg_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] mag_mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid    = (count_reg != '0);
    assign head.negative = neg_mem[rd_ptr_reg];
    assign head_mag      = mag_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            neg_mem[wr_ptr_reg] <= push.negative;
            mag_mem[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

// ----- rtl/sitoa_conv.sv -----
// ----------------------------------------------------------------------------
// sitoa_conv
// Iterative shift-and-add-3 binary to BCD converter, STEP_BITS bits a cycle.
// ----------------------------------------------------------------------------
module sitoa_conv #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sitoa_pkg::sitoa_ctl_t                  head,
    input  logic [VALUE_WIDTH-1:0]                 head_mag,
    output logic                                   pop,
    output sitoa_pkg::sitoa_ctl_t                  res,
    output logic [4*sitoa_pkg::num_digits(VALUE_WIDTH)-1:0] res_bcd,
    input  logic                                   res_ready
);

    localparam int DIGITS = sitoa_pkg::num_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int SB     = sitoa_pkg::STEP_BITS;
    localparam int NSTEP  = (VALUE_WIDTH + SB - 1) / SB;
    localparam int PAD_W  = NSTEP * SB;
    localparam int CNT_W  = $clog2(NSTEP + 1);

    sitoa_pkg::sitoa_conv_state_t state_reg;
    sitoa_pkg::sitoa_conv_state_t state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [PAD_W-1:0] shift_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             neg_reg;
    logic [PAD_W-1:0] shift_next;
    logic [BCD_W-1:0] bcd_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sitoa_pkg::CONV_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = sitoa_pkg::CONV_RUN;
                end
            end
            sitoa_pkg::CONV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = sitoa_pkg::CONV_DONE;
                end
            end
            sitoa_pkg::CONV_DONE:
            begin
                if (res_ready)
                begin
                    state_next = sitoa_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = sitoa_pkg::CONV_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        pop          = 1'b0;
        res.valid    = 1'b0;
        res.negative = neg_reg;
        unique case (state_reg)
            sitoa_pkg::CONV_IDLE: pop       = head.valid;
            sitoa_pkg::CONV_RUN:  pop       = 1'b0;
            sitoa_pkg::CONV_DONE: res.valid = 1'b1;
            default:              pop       = 1'b0;
        endcase
    end

    assign res_bcd = bcd_reg;

    // Double dabble for one register update: adjust digits, shift one bit in, repeat STEP_BITS times.
    always_comb
    begin
        bcd_next   = bcd_reg;
        shift_next = shift_reg;
        for (int b = 0; b < SB; b++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd_next[d*4 +: 4] >= 4'd5)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            bcd_next   = {bcd_next[BCD_W-2:0], shift_next[PAD_W-1]};
            shift_next = {shift_next[PAD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitoa_pkg::CONV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cnt_reg <= CNT_W'(NSTEP);
            end
            else if (state_reg == sitoa_pkg::CONV_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            shift_reg <= PAD_W'(head_mag);
            bcd_reg   <= '0;
            neg_reg   <= head.negative;
        end
        else if (state_reg == sitoa_pkg::CONV_RUN)
        begin
            shift_reg <= shift_next;
            bcd_reg   <= bcd_next;
        end
    end

endmodule

// ----- rtl/sitoa_emit.sv -----
// ----------------------------------------------------------------------------
// sitoa_emit
// Character sequencer: sign, then digits from the leading nonzero one down.
// ----------------------------------------------------------------------------
module sitoa_emit #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sitoa_pkg::sitoa_ctl_t                  res,
    input  logic [4*sitoa_pkg::num_digits(VALUE_WIDTH)-1:0] res_bcd,
    output logic                                   res_ready,
    output logic                                   char_valid,
    input  logic                                   char_stall,
    output logic [7:0]                             char_code,
    output logic                                   last_char
);

    localparam int DIGITS = sitoa_pkg::num_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int IDX_W  = $clog2(DIGITS);

    logic             busy_reg;
    logic             minus_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             char_valid_reg;
    logic [7:0]       char_code_reg;
    logic             last_char_reg;
    logic             adv;
    logic             load;
    logic             step;
    logic [IDX_W-1:0] lead;
    logic [3:0]       digit;

    assign adv       = !char_valid_reg || !char_stall;
    assign res_ready = !busy_reg;
    assign load      = res.valid && !busy_reg;
    assign step      = busy_reg && adv;
    assign digit     = bcd_reg[{ptr_reg, 2'b00} +: 4];

    // Highest nonzero digit; zero keeps a single digit.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (res_bcd[i*4 +: 4] != 4'd0)
            begin
                lead = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            minus_reg      <= 1'b0;
            ptr_reg        <= '0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= 1'b1;
                minus_reg <= res.negative;
                ptr_reg   <= lead;
            end
            else if (step)
            begin
                if (minus_reg)
                begin
                    minus_reg <= 1'b0;
                end
                else if (ptr_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg <= ptr_reg - 1'b1;
                end
            end
            if (adv)
            begin
                char_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= res_bcd;
        end
        if (step)
        begin
            char_code_reg <= minus_reg ? sitoa_pkg::CHAR_MINUS
                                       : sitoa_pkg::CHAR_ZERO + {4'd0, digit};
            last_char_reg <= !minus_reg && (ptr_reg == '0);
        end
    end

    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign last_char  = last_char_reg;

endmodule

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed two's complement value into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each beat on the item channel carries one VALUE_WIDTH-bit signed value; the
// block answers with its decimal text on the char channel, one character per
// beat, most significant first: a '-' for negative values, then the digits
// with no leading zeros (zero gives a single '0'), the last character flagged
// by last_char. The most negative value converts exactly. Each magnitude goes
// through the shift-and-add-3 converter, which folds four bits per cycle;
// conversion of the next item overlaps the emission of the current one. Input
// beats are taken into a two-entry queue, so a stalled char channel does not
// stall the input until that queue is full. No configuration, no state kept
// between items.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          char_valid,
    input  logic                          char_stall,
    output logic [7:0]                    char_code,
    output logic                          last_char
);

    localparam int BCD_W = 4 * sitoa_pkg::num_digits(VALUE_WIDTH);

    sitoa_pkg::sitoa_ctl_t  push;
    sitoa_pkg::sitoa_ctl_t  head;
    sitoa_pkg::sitoa_ctl_t  res;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic [VALUE_WIDTH-1:0] head_mag;
    logic [BCD_W-1:0]       res_bcd;
    logic                   push_ready;
    logic                   pop;
    logic                   res_ready;

    // Front: register the beat, split off sign and magnitude.
    sitoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .push       (push),
        .push_mag   (push_mag),
        .push_ready (push_ready)
    );

    // Decouple the front from the converter.
    sitoa_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_mag   (push_mag),
        .push_ready (push_ready),
        .head       (head),
        .head_mag   (head_mag),
        .pop        (pop)
    );

    // Back end, part one: magnitude to packed BCD digits.
    sitoa_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_mag  (head_mag),
        .pop       (pop),
        .res       (res),
        .res_bcd   (res_bcd),
        .res_ready (res_ready)
    );

    // Back end, part two: walk sign and digits out through the output register.
    sitoa_emit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_bcd    (res_bcd),
        .res_ready  (res_ready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Feeds signed 32-bit values to the item channel and predicts each value's
// decimal text: a '-' for negative values, then the digits with no leading
// zeros, the last character flagged. Every character beat is checked in order
// against that prediction. Directed corners come first: zero, the extremes,
// decade boundaries and alternating bit patterns. Random values follow, a quarter
// of them shaped by digit count so that every text length shows up, the rest raw,
// small or next to a power of ten. The sender works in bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = sitoa_pkg::VALUE_WIDTH_DEF;
    localparam int RANDOM_VALUES = 200;

    // One character beat of the converter's output.
    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } char_beat_t;

    // Receiver stall behavior, reselected every stall window.
    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY
    } stall_mode_t;

    // How a random value is picked.
    typedef enum int {
        PICK_RAW,
        PICK_DIGITS,
        PICK_SMALL,
        PICK_DECADE
    } value_pick_t;

    // ------------------------------------------------------------------------
    // Scoreboard: expand each accepted value into its expected characters,
    // and compare every character beat against the oldest one pending.
    // ------------------------------------------------------------------------
    class text_scoreboard;
        char_beat_t pending_chars[$];
        int mismatches;
        int chars_checked;
        int values_noted;
        int negatives_noted;
        int zeros_noted;
        int longest_text;

        function new();
            mismatches      = 0;
            chars_checked   = 0;
            values_noted    = 0;
            negatives_noted = 0;
            zeros_noted     = 0;
            longest_text    = 0;
        endfunction

        function void note_value(input logic [VW-1:0] v);
            logic [VW-1:0] magnitude;
            logic [7:0]    digits[$];
            char_beat_t    beat;
            logic          negative;
            int            text_len;

            negative  = v[VW-1];
            // Two's complement negate; the most negative value maps to itself,
            // which read as unsigned is exactly its magnitude.
            magnitude = negative ? (~v + 1'b1) : v;
            do
            begin
                digits.push_front(sitoa_pkg::CHAR_ZERO + 8'(magnitude % sitoa_pkg::RADIX));
                magnitude = VW'(magnitude / sitoa_pkg::RADIX);
            end
            while (magnitude != '0);

            if (negative)
            begin
                beat.code    = sitoa_pkg::CHAR_MINUS;
                beat.is_last = 1'b0;
                pending_chars.push_back(beat);
                negatives_noted++;
            end
            foreach (digits[i])
            begin
                beat.code    = digits[i];
                beat.is_last = (i == digits.size() - 1);
                pending_chars.push_back(beat);
            end

            text_len = digits.size() + (negative ? 1 : 0);
            if (text_len > longest_text)
                longest_text = text_len;
            if (v == '0)
                zeros_noted++;
            values_noted++;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_char(input logic [7:0] code, input logic is_last);
            char_beat_t want;

            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          code, is_last));
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (code !== want.code)
                report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                          code, want.code));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("last_char %0b, want %0b on char 0x%02h",
                                          is_last, want.is_last, want.code));
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and its connections
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic signed [VW-1:0] value;
    logic                 char_valid;
    logic                 char_stall = 1'b0;
    logic [7:0]           char_code;
    logic                 last_char;

    text_scoreboard sb = new();

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH (VW)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    // ------------------------------------------------------------------------
    // Sender tasks. Both are entered just after a rising edge and return just
    // after one, so every drive below lands on a clock edge.
    // ------------------------------------------------------------------------

    // Present one value and hold it until the beat is taken.
    task automatic push_value(input logic [VW-1:0] v);
        item_valid <= 1'b1;
        value      <= v;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_value(v);
    endtask

    // Drop valid and wait until every pending character has come out.
    task automatic drain_text();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each accepted character beat, then pick the next stall.
    // The stall pattern is a 16-bit word replayed bit by bit, and at the start of each
    // window the mode is redrawn so that quiet stretches alternate with
    // light and heavy back-pressure.
    // ------------------------------------------------------------------------
    int          stall_phase = 0;
    logic [15:0] stall_pattern = '0;
    stall_mode_t stall_mode = STALL_NONE;

    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
            sb.check_char(char_code, last_char);

        if (stall_phase % 128 == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
            case (stall_mode)
                STALL_NONE:   stall_pattern = '0;
                STALL_SPARSE: stall_pattern = 16'($urandom & $urandom);
                STALL_HEAVY:  stall_pattern = 16'($urandom | $urandom);
                default:      stall_pattern = '0;
            endcase
        end
        char_stall  <= stall_pattern[stall_phase % 16];
        stall_phase = stall_phase + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Zero, one-digit edges, decade boundaries, both extremes, the most
    // negative value, and alternating bit patterns.
    logic [VW-1:0] corner_values[$] = '{
        32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
        32'd10,         -32'sd10,       32'd99,         32'd100,
        -32'sd9,        32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,
        32'd999999999,  32'd1000000000, -32'sd999999999, -32'sd1000000000,
        32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd7,          -32'sd100
    };

    initial
    begin
        int            sent;
        int            burst_len;
        int            gap_len;
        int            digit_count;
        value_pick_t   pick;
        longint        lo;
        longint        hi;
        longint        mag;
        logic [VW-1:0] v;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        value      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, back to back.
        foreach (corner_values[i])
            push_value(corner_values[i]);
        drain_text();

        // Random values in bursts with gaps between them.
        sent = 0;
        while (sent < RANDOM_VALUES)
        begin
            burst_len = $urandom_range(1, 8);
            for (int b = 0; b < burst_len && sent < RANDOM_VALUES; b++)
            begin
                pick = value_pick_t'($urandom_range(PICK_RAW, PICK_DECADE));
                case (pick)
                    PICK_RAW:
                        v = VW'($urandom);
                    PICK_DIGITS:
                    begin
                        // Uniform over text lengths rather than over values.
                        digit_count = $urandom_range(1, 10);
                        lo = 1;
                        repeat (digit_count - 1) lo = lo * 10;
                        hi = lo * 10 - 1;
                        if (hi > 64'sd2147483647)
                            hi = 64'sd2147483647;
                        mag = lo + (longint'({$urandom, $urandom} >> 1) % (hi - lo + 1));
                        v = VW'(mag);
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    PICK_SMALL:
                    begin
                        v = VW'($urandom_range(0, 20));
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    default:
                    begin
                        // One either side of a power of ten, or the power itself.
                        mag = 1;
                        repeat ($urandom_range(0, 9)) mag = mag * 10;
                        v = VW'(mag + $urandom_range(0, 2) - 1);
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                endcase
                push_value(v);
                sent++;
            end

            // Let the output run dry now and then before going on.
            if (sent % 70 < burst_len)
                drain_text();
            else
            begin
                gap_len = $urandom_range(0, 12);
                if (gap_len > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (gap_len) @(posedge clk);
                end
            end
        end

        drain_text();
        // Watch a little longer for any character beyond the expected ones.
        repeat (30) @(posedge clk);

        $display("Covered %0d values (%0d negative, %0d zero), %0d characters checked,",
                 sb.values_noted, sb.negatives_noted, sb.zeros_noted, sb.chars_checked);
        $display("longest text %0d characters, %0d mismatches.",
                 sb.longest_text, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("signed_int_to_decimal_ascii verification clean");
        else
            $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d characters still pending.", sb.pending());
        $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule
